### rtl/nth_root_bisection_core_assert.svh
// Assertion macros for the nth root bisection core.
// Included by the top level; relies on nothing else.
`ifndef NTH_ROOT_BISECTION_CORE_ASSERT_SVH
`define NTH_ROOT_BISECTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define NRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nrb_pkg.sv
// Types and constants shared by the nth root bisection core.
// No dependencies.
`timescale 1ns / 1ps

package nrb_pkg;

  localparam int NRB_FRAC_BITS = 20;
  localparam int NRB_RAD_BITS  = 32;
  localparam int NRB_EXP_W     = 5;
  localparam int NRB_RADICAND_W = 32;
  localparam int NRB_OUT_W     = 52;
  // datapath width of the bracket, midpoint and power
  localparam int NRB_W         = NRB_RAD_BITS + NRB_FRAC_BITS;
  localparam int NRB_HALF_W    = (NRB_W + 1) / 2;
  localparam int NRB_PROD_W    = 2 * NRB_W;

  localparam logic [NRB_W-1:0] NRB_ONE = NRB_W'(1) << NRB_FRAC_BITS;

  typedef struct packed {
    logic [NRB_EXP_W-1:0]      exponent;
    logic [NRB_RADICAND_W-1:0] radicand;
  } nrb_in_t;

  typedef struct packed {
    logic [NRB_OUT_W-1:0] root_low;
    logic [NRB_OUT_W-1:0] root_high;
  } nrb_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POW,
    S_MUL,
    S_DECIDE,
    S_DONE
  } nrb_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } nrb_mul_sts_t;

endpackage

### rtl/nrb_fxmul.sv
// Multi-cycle unsigned multiplier: four half-width partial products, one per cycle.
// Depends on nrb_pkg.
`timescale 1ns / 1ps

module nrb_fxmul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nrb_pkg::NRB_W-1:0]    a,
  input  logic [nrb_pkg::NRB_W-1:0]    b,
  output logic [nrb_pkg::NRB_PROD_W-1:0] product,
  output nrb_pkg::nrb_mul_sts_t        sts
);
  import nrb_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [1:0]            part_r, part_nxt;
  logic [NRB_PROD_W-1:0] acc_r, acc_nxt;

  logic [NRB_HALF_W-1:0]   a_sel, b_sel;
  logic [2*NRB_HALF_W-1:0] pp;
  logic [NRB_PROD_W-1:0]   pp_ext, pp_shift;

  // part[1] picks the half of a, part[0] the half of b
  assign a_sel = part_r[1] ? NRB_HALF_W'(a[NRB_W-1:NRB_HALF_W]) : a[NRB_HALF_W-1:0];
  assign b_sel = part_r[0] ? NRB_HALF_W'(b[NRB_W-1:NRB_HALF_W]) : b[NRB_HALF_W-1:0];
  assign pp     = a_sel * b_sel;
  assign pp_ext = NRB_PROD_W'(pp);

  always_comb begin
    case (part_r)
      2'd0:    pp_shift = pp_ext;
      2'd1:    pp_shift = pp_ext << NRB_HALF_W;
      2'd2:    pp_shift = pp_ext << NRB_HALF_W;
      2'd3:    pp_shift = pp_ext << (2 * NRB_HALF_W);
      default: pp_shift = pp_ext;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    part_nxt = part_r;
    acc_nxt  = acc_r;
    if (busy_r) begin
      acc_nxt  = acc_r + pp_shift;
      part_nxt = part_r + 2'd1;
      if (part_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      part_nxt = 2'd0;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    part_r <= part_nxt;
    acc_r  <= acc_nxt;
  end

  assign product  = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### rtl/nth_root_bisection_core.sv
// Nth root bisection core: top level, sequencer and bracket registers.
// Depends on nrb_pkg, nrb_fxmul and nth_root_bisection_core_assert.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one word {exponent, radicand}. Exponents
//   above MAX_EXP are treated as MAX_EXP. The core returns one word
//   {root_low, root_high} on out_valid/out_ready: the Q32.20 bracket around
//   the real nth root, narrowed until it is at most one lsb wide.
//   One word is processed at a time; in_ready is high only while idle.
//   Every bisection step runs k multiplies (k <= exponent, fewer when
//   the power saturates above the radicand). The bracket starts
//   [1.0, radicand] so there are up to 52 steps. The shared
//   partial-product multiplier sets the step time. Radicand 0 or 1
//   returns without a bisection step.
//   The result sits in an output register; a new word is accepted while it
//   waits, and the finished bracket of that next word holds until the
//   output register frees up.
//   Reset (rst_n low, synchronous) returns to idle and drops out_valid.
`timescale 1ns / 1ps
`include "nth_root_bisection_core_assert.svh"

module nth_root_bisection_core #(
  parameter int MAX_EXP = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  nrb_pkg::nrb_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output nrb_pkg::nrb_out_t out_data
);
  import nrb_pkg::*;

  localparam logic [NRB_EXP_W-1:0] EXP_CAP = NRB_EXP_W'(MAX_EXP);
  localparam int QW = NRB_PROD_W - NRB_FRAC_BITS;

  nrb_state_t state_r, state_nxt;
  logic [NRB_W-1:0] lo_r, lo_nxt;
  logic [NRB_W-1:0] hi_r, hi_nxt;
  logic [NRB_W-1:0] tgt_r, tgt_nxt;
  logic [NRB_W-1:0] mid_r, mid_nxt;
  logic [NRB_W-1:0] acc_r, acc_nxt;
  logic [NRB_EXP_W-1:0] n_r, n_nxt;
  logic [NRB_EXP_W-1:0] cnt_r, cnt_nxt;
  logic     out_valid_r, out_valid_nxt;
  nrb_out_t out_r, out_nxt;

  logic                  mul_start;
  logic [NRB_PROD_W-1:0] product;
  nrb_mul_sts_t          mul_sts;

  logic [NRB_W-1:0] tgt_in;
  logic [NRB_W:0]   sum;
  logic [QW-1:0]    prod_q;

  nrb_fxmul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (acc_r),
    .b       (mid_r),
    .product (product),
    .sts     (mul_sts)
  );

  assign tgt_in = NRB_W'(in_data.radicand[NRB_RAD_BITS-1:0]) << NRB_FRAC_BITS;
  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign prod_q = product[NRB_PROD_W-1:NRB_FRAC_BITS];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    tgt_nxt       = tgt_r;
    mid_nxt       = mid_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mul_start     = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lo_nxt    = NRB_ONE;
          hi_nxt    = tgt_in;
          tgt_nxt   = tgt_in;
          n_nxt     = (in_data.exponent > EXP_CAP) ? EXP_CAP : in_data.exponent;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // keep going while the bracket is wider than one lsb
        if ({1'b0, hi_r} > ({1'b0, lo_r} + (NRB_W + 1)'(1))) begin
          mid_nxt   = sum[NRB_W:1];
          acc_nxt   = NRB_ONE;
          cnt_nxt   = '0;
          state_nxt = S_POW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POW: begin
        if (cnt_r == n_r) begin
          state_nxt = S_DECIDE;
        end else begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_sts.done) begin
          cnt_nxt = cnt_r + NRB_EXP_W'(1);
          // past the target: pin just above it and stop multiplying
          if (prod_q > QW'(tgt_r)) begin
            acc_nxt   = tgt_r + NRB_W'(1);
            state_nxt = S_DECIDE;
          end else begin
            acc_nxt   = prod_q[NRB_W-1:0];
            state_nxt = S_POW;
          end
        end
      end
      S_DECIDE: begin
        if (acc_r < tgt_r) lo_nxt = mid_r;
        else               hi_nxt = mid_r;
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.root_low  = NRB_OUT_W'(lo_r);
          out_nxt.root_high = NRB_OUT_W'(hi_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tgt_r <= tgt_nxt;
    mid_r <= mid_nxt;
    acc_r <= acc_nxt;
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  `NRB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready,
    "core still ready right after taking a word")
  `NRB_ASSERT_NOW(a_mid_inside, clk, rst_n, state_r == S_POW,
    (lo_r < mid_r) && (mid_r < hi_r), "midpoint outside the bracket")
  `NRB_ASSERT_NOW(a_cnt_bound, clk, rst_n, (state_r == S_POW) || (state_r == S_MUL),
    cnt_r <= n_r, "multiply count past the exponent")
  `NRB_ASSERT_NOW(a_mul_idle_start, clk, rst_n, mul_start,
    !mul_sts.busy && !mul_sts.done, "multiplier started while in use")

endmodule
